### design/htis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htis_pkg: shared types and constants of the heightmap triangle sampler
// item kinds, store geometry, register reset value and field widths
// ----------------------------------------------------------------------------
package htis_pkg;

  // item kind carried in the input tuser bit
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // default geometry
  localparam int GRID_SIZE_DEF = 256;
  localparam int FRAC_BITS_DEF = 12;

  // height store: fixed 64k entries, addresses wrap to 16 bits
  localparam int STORE_AW    = 16;
  localparam int STORE_DEPTH = 1 << STORE_AW;
  localparam int HEIGHT_W    = 16;

  // grid_per_unit register, unsigned q8.16
  localparam int          GPU_W     = 24;
  localparam logic [23:0] GPU_RESET = 24'd65536;

  // query coordinates, unsigned q16.16, and their scaled product
  localparam int COORD_W = 32;
  localparam int PROD_W  = COORD_W + GPU_W;

  // result width, signed
  localparam int OUT_W = 30;

endpackage

### design/heightmap_triangle_interp_sampler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightmap_triangle_interp_sampler_top: pipelined heightmap height sampler
// height store with streaming writes and triangle-split bilinear queries
// ----------------------------------------------------------------------------
// The block holds a GRID_SIZE x GRID_SIZE grid of 16-bit heights in a 64k-entry
// store (address = row * GRID_SIZE + column, wrapped to 16 bits). An input item
// with tuser = 0 writes one entry; an item with tuser = 1 is a query at world
// (x, z) in unsigned q16.16 and returns one result item: the height at that
// point in signed q.FRAC_BITS plus an out-of-range flag. Writes return
// nothing. The block takes one item per clock cycle while m_tready lets the
// output register drain; the four corner fetches of a query are served together
// by two copies of the store, each read at two addresses, so the store ports
// never stall the flow of items. A write updates
// both copies in the same pipeline stage where queries read, so a query always
// sees every write accepted before it. Entries that were never written read as
// garbage; there is no clearing pass after reset. grid_per_unit may only be
// changed while no item is in flight.
// ----------------------------------------------------------------------------
module heightmap_triangle_interp_sampler_top #(
  parameter int GRID_SIZE = htis_pkg::GRID_SIZE_DEF,
  parameter int FRAC_BITS = htis_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // write_index[15:0], height_value[15:0],
                                 // query_x[31:0], query_z[31:0]
  input  logic [0:0]  s_tuser,   // op
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // height_out[29:0], zero pad[1:0]
  output logic [0:0]  m_tuser,   // out_of_range
  // grid_per_unit register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data   // grid_per_unit, unsigned q8.16
);
  import htis_pkg::*;

  // cell index width and weight width (fraction plus the value 1.0)
  localparam int IW  = (GRID_SIZE > 2) ? $clog2(GRID_SIZE) : 1;
  localparam int FW  = FRAC_BITS + 1;
  localparam logic [FW-1:0] ONE = FW'(1 << FRAC_BITS);
  // corner width: adjusted corner spans -65535 .. 131070
  localparam int CW  = HEIGHT_W + 2;
  // first interpolation stage and accumulator widths
  localparam int TW  = CW + FW + 1;
  localparam int AW  = TW + FW + 2;
  // rounded result width and saturation compare width
  localparam int RW  = AW + 1 - FRAC_BITS;
  localparam int EW  = (RW > OUT_W + 1) ? RW : OUT_W + 1;
  localparam logic signed [EW-1:0] OUT_MAX = EW'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
  localparam logic signed [EW-1:0] OUT_MIN = EW'(-(64'sd1 <<< (OUT_W - 1)));
  localparam logic signed [AW:0]   HALF    = (AW + 1)'(1 << (FRAC_BITS - 1));

  typedef struct packed {
    logic [IW-1:0] idx;
    logic [IW-1:0] nxt;
    logic [FW-1:0] frac;
    logic          clamp;
  } coord_t;

  // splits a scaled coordinate into cell index, neighbor index and fraction
  function automatic coord_t split_coord(input logic [PROD_W-1:0] p);
    coord_t          c;
    logic [GPU_W-1:0] ip;
    logic [IW:0]     inc;
    ip = p[PROD_W-1:COORD_W];
    if (ip >= GPU_W'(GRID_SIZE)) begin
      c.idx   = IW'(GRID_SIZE - 1);
      c.frac  = ONE;
      c.clamp = (ip > GPU_W'(GRID_SIZE));
    end else begin
      c.idx   = ip[IW-1:0];
      c.frac  = {1'b0, p[COORD_W-1 -: FRAC_BITS]};
      c.clamp = 1'b0;
    end
    inc = {1'b0, c.idx} + (IW + 1)'(1);
    // neighbor past the last row or column clamps to the edge
    c.nxt = (inc < (IW + 1)'(GRID_SIZE)) ? inc[IW-1:0] : IW'(GRID_SIZE - 1);
    return c;
  endfunction

  // row-major store address, wrapped to the store size
  function automatic logic [STORE_AW-1:0] cell_addr(input logic [IW-1:0] row,
                                                    input logic [IW-1:0] col);
    logic [31:0] full;
    full = 32'(row) * 32'(GRID_SIZE) + 32'(col);
    return full[STORE_AW-1:0];
  endfunction

  // -------------------------------------------------------------------------
  // configuration register, always writable
  // -------------------------------------------------------------------------
  logic [GPU_W-1:0] grid_per_unit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_per_unit <= GPU_RESET;
    end else if (cfg_valid) begin
      grid_per_unit <= cfg_data;
    end
  end

  // -------------------------------------------------------------------------
  // pipeline registers; each stage loads when it is empty or its successor
  // loads, so bubbles collapse and a stall reaches the input only when
  // every stage is full
  // -------------------------------------------------------------------------
  logic ld1, ld2, ld3, ld4, ld5, ld6, ld7, ld_out;

  // stage 1: captured item
  logic                 s1_valid;
  op_t                  s1_op;
  logic [STORE_AW-1:0]  s1_widx;
  logic [HEIGHT_W-1:0]  s1_hval;
  logic [COORD_W-1:0]   s1_qx, s1_qz;

  // stage 2: scaled coordinates
  logic                 s2_valid;
  op_t                  s2_op;
  logic [STORE_AW-1:0]  s2_widx;
  logic [HEIGHT_W-1:0]  s2_hval;
  logic [PROD_W-1:0]    s2_px, s2_pz;

  // stage 3: corner addresses and fractions
  logic                 s3_valid;
  op_t                  s3_op;
  logic [STORE_AW-1:0]  s3_widx;
  logic [HEIGHT_W-1:0]  s3_hval;
  logic [STORE_AW-1:0]  s3_a_t1, s3_a_t2, s3_a_b1, s3_a_b2;
  logic [FW-1:0]        s3_fx, s3_fz;
  logic                 s3_flag;

  // stage 4: fetched corners (read data registers of the store)
  logic                 s4_valid;
  logic [HEIGHT_W-1:0]  s4_t1, s4_t2, s4_b1, s4_b2;
  logic [FW-1:0]        s4_fx, s4_fz;
  logic                 s4_flag;

  // stage 5: corners after the diagonal replacement
  logic                 s5_valid;
  logic signed [CW-1:0] s5_t1, s5_t2, s5_b1, s5_b2;
  logic [FW-1:0]        s5_fx, s5_fz;
  logic                 s5_flag;

  // stage 6: interpolated along x
  logic                 s6_valid;
  logic signed [TW-1:0] s6_t, s6_b;
  logic [FW-1:0]        s6_fz;
  logic                 s6_flag;

  // stage 7: interpolated along z, 2*FRAC_BITS fraction bits
  logic                 s7_valid;
  logic signed [AW-1:0] s7_acc;
  logic                 s7_flag;

  // output register
  logic                 out_valid;
  logic [OUT_W-1:0]     out_height;
  logic                 out_flag;

  assign ld_out   = !out_valid || m_tready;
  assign ld7      = !s7_valid || ld_out;
  assign ld6      = !s6_valid || ld7;
  assign ld5      = !s5_valid || ld6;
  assign ld4      = !s4_valid || ld5;
  assign ld3      = !s3_valid || ld4;
  assign ld2      = !s2_valid || ld3;
  assign ld1      = !s1_valid || ld2;
  assign s_tready = ld1;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      s6_valid  <= 1'b0;
      s7_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ld1)    s1_valid  <= s_tvalid;
      if (ld2)    s2_valid  <= s1_valid;
      if (ld3)    s3_valid  <= s2_valid;
      // a write ends in stage 3, where it updates the store
      if (ld4)    s4_valid  <= s3_valid && (s3_op == OP_QUERY);
      if (ld5)    s5_valid  <= s4_valid;
      if (ld6)    s6_valid  <= s5_valid;
      if (ld7)    s7_valid  <= s6_valid;
      if (ld_out) out_valid <= s7_valid;
    end
  end

  // stage 1: unpack the item
  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_op   <= op_t'(s_tuser[0]);
      s1_widx <= s_tdata[15:0];
      s1_hval <= s_tdata[31:16];
      s1_qx   <= s_tdata[63:32];
      s1_qz   <= s_tdata[95:64];
    end
  end

  // stage 2: scale both coordinates by grid_per_unit
  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_op   <= s1_op;
      s2_widx <= s1_widx;
      s2_hval <= s1_hval;
      s2_px   <= PROD_W'(s1_qx) * PROD_W'(grid_per_unit);
      s2_pz   <= PROD_W'(s1_qz) * PROD_W'(grid_per_unit);
    end
  end

  // stage 3: cell indices, edge clamps and the four corner addresses
  coord_t cx, cz;

  assign cx = split_coord(s2_px);
  assign cz = split_coord(s2_pz);

  always_ff @(posedge clk) begin
    if (ld3) begin
      s3_op   <= s2_op;
      s3_widx <= s2_widx;
      s3_hval <= s2_hval;
      s3_a_t1 <= cell_addr(cz.idx, cx.idx);
      s3_a_t2 <= cell_addr(cz.idx, cx.nxt);
      s3_a_b1 <= cell_addr(cz.nxt, cx.idx);
      s3_a_b2 <= cell_addr(cz.nxt, cx.nxt);
      s3_fx   <= cx.frac;
      s3_fz   <= cz.frac;
      s3_flag <= cx.clamp || cz.clamp;
    end
  end

  // stage 4: height store, two copies with two read ports each
  logic [HEIGHT_W-1:0] mem_top [STORE_DEPTH];
  logic [HEIGHT_W-1:0] mem_bot [STORE_DEPTH];
  logic                wr_en;

  assign wr_en = ld4 && s3_valid && (s3_op == OP_WRITE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_top[s3_widx] <= s3_hval;
    end
    if (ld4) begin
      s4_t1 <= mem_top[s3_a_t1];
      s4_t2 <= mem_top[s3_a_t2];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_bot[s3_widx] <= s3_hval;
    end
    if (ld4) begin
      s4_b1 <= mem_bot[s3_a_b1];
      s4_b2 <= mem_bot[s3_a_b2];
    end
  end

  always_ff @(posedge clk) begin
    if (ld4) begin
      s4_fx   <= s3_fx;
      s4_fz   <= s3_fz;
      s4_flag <= s3_flag;
    end
  end

  // stage 5: replace the corner beyond the diagonal of the cell
  logic signed [CW-1:0] c_t1, c_t2, c_b1, c_b2;
  logic                 near_tri;

  assign c_t1     = $signed({2'b00, s4_t1});
  assign c_t2     = $signed({2'b00, s4_t2});
  assign c_b1     = $signed({2'b00, s4_b1});
  assign c_b2     = $signed({2'b00, s4_b2});
  assign near_tri = ({1'b0, s4_fx} + {1'b0, s4_fz}) <= {1'b0, ONE};

  always_ff @(posedge clk) begin
    if (ld5) begin
      s5_t2   <= c_t2;
      s5_b1   <= c_b1;
      if (near_tri) begin
        s5_t1 <= c_t1;
        s5_b2 <= c_b1 + c_t2 - c_t1;
      end else begin
        s5_t1 <= c_b1 + c_t2 - c_b2;
        s5_b2 <= c_b2;
      end
      s5_fx   <= s4_fx;
      s5_fz   <= s4_fz;
      s5_flag <= s4_flag;
    end
  end

  // stage 6: interpolate along x
  logic signed [FW:0] wx1, wx0;

  assign wx1 = $signed({1'b0, s5_fx});
  assign wx0 = $signed({1'b0, ONE - s5_fx});

  always_ff @(posedge clk) begin
    if (ld6) begin
      s6_t    <= TW'(s5_t1 * wx0) + TW'(s5_t2 * wx1);
      s6_b    <= TW'(s5_b1 * wx0) + TW'(s5_b2 * wx1);
      s6_fz   <= s5_fz;
      s6_flag <= s5_flag;
    end
  end

  // stage 7: interpolate along z
  logic signed [FW:0] wz1, wz0;

  assign wz1 = $signed({1'b0, s6_fz});
  assign wz0 = $signed({1'b0, ONE - s6_fz});

  always_ff @(posedge clk) begin
    if (ld7) begin
      s7_acc  <= AW'(s6_t * wz0) + AW'(s6_b * wz1);
      s7_flag <= s6_flag;
    end
  end

  // output: round half up to FRAC_BITS fraction bits, then saturate
  logic signed [AW:0]   acc_rnd;
  logic signed [RW-1:0] h_rnd;
  logic signed [EW-1:0] h_ext;
  logic [OUT_W-1:0]     h_sat;

  assign acc_rnd = $signed({s7_acc[AW-1], s7_acc}) + HALF;
  assign h_rnd   = RW'(acc_rnd >>> FRAC_BITS);
  assign h_ext   = EW'(h_rnd);

  always_comb begin
    if (h_ext > OUT_MAX) begin
      h_sat = OUT_MAX[OUT_W-1:0];
    end else if (h_ext < OUT_MIN) begin
      h_sat = OUT_MIN[OUT_W-1:0];
    end else begin
      h_sat = h_ext[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_height <= h_sat;
      out_flag   <= s7_flag;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_height};
  assign m_tuser  = out_flag;

  // -------------------------------------------------------------------------
  // checks
  // -------------------------------------------------------------------------

  // input only stalls when every stage is full and the result is not taken
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled while the pipeline could move");

  // a write leaving the store stage never becomes a result
  assert property (@(posedge clk) disable iff (rst)
    (s3_valid && (s3_op == OP_WRITE) && ld4) |=> !s4_valid)
    else $error("write item passed the store stage");

  // fractions never exceed 1.0 after the edge clamp
  assert property (@(posedge clk) disable iff (rst)
    s4_valid |-> ((s4_fx <= ONE) && (s4_fz <= ONE)))
    else $error("fraction above 1.0");

  // no result straight after reset
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule
